// ----- hdl/fcfsa_pkg.sv -----
// shared types, constants and a helper function for the frame clock accumulator
package fcfsa_pkg;

    // data path widths
    localparam int DATA_W     = 64;
    localparam int TICK_WIDTH = 64;
    localparam int REQ_W      = 3;

    // saturation limits
    localparam logic [DATA_W-1:0] WORD_MAX = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] TICK_MAX = WORD_MAX >> (DATA_W - TICK_WIDTH);

    // divider iteration count and counter width
    localparam int DIV_STEPS = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // configuration port geometry
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 4;
    localparam int CFG_SEL_BIT  = 3;
    localparam logic CFG_IDX_STEP = 1'b0;
    localparam logic CFG_IDX_LOCK = 1'b1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_UPDATE   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADVANCE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_START    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_STOP     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PAUSE    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RESUME   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_CONSUME  = 3'd6;
    localparam logic [REQ_W-1:0] REQ_LAST_CLK = REQ_RESUME;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DELTA,
        ST_ACCUM,
        ST_DIVGO,
        ST_DIVWAIT,
        ST_FINISH,
        ST_RESP
    } fsm_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // decoded configuration write
    typedef struct packed {
        logic              step_we;
        logic              lock_we;
        logic [DATA_W-1:0] data;
    } cfg_wr_t;

    // configuration readback
    typedef struct packed {
        logic [DATA_W-1:0] step_size;
        logic              lock;
    } cfg_rd_t;

    // response payload
    typedef struct packed {
        logic              accepted;
        logic [DATA_W-1:0] consumed_steps;
        logic [DATA_W-1:0] last_tick;
        logic [DATA_W-1:0] frame_delta;
        logic [DATA_W-1:0] total_elapsed;
        logic [DATA_W-1:0] frames_done;
        logic [DATA_W-1:0] pending_steps;
        logic              is_running;
        logic              is_paused;
        logic [DATA_W-1:0] change_count;
    } rsp_t;

    // saturating add clipped at top
    function automatic logic [DATA_W-1:0] sat_add(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic [DATA_W-1:0] top
    );
        logic [DATA_W-1:0] room;
        room = top - a;
        if ((a > top) || (room < b))
        begin
            return top;
        end
        return a + b;
    endfunction

endpackage

// ----- hdl/fcfsa_if.sv -----
// request and response channel interfaces of the frame clock accumulator

// command channel
interface fcfsa_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [fcfsa_pkg::REQ_W-1:0]          req_type;
    logic [fcfsa_pkg::DATA_W-1:0]         tick_value;

    modport source (output valid, output req_type, output tick_value, input ready);
    modport sink   (input valid, input req_type, input tick_value, output ready);
endinterface

// response channel
interface fcfsa_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 accepted;
    logic [fcfsa_pkg::DATA_W-1:0]         consumed_steps;
    logic [fcfsa_pkg::DATA_W-1:0]         last_tick;
    logic [fcfsa_pkg::DATA_W-1:0]         frame_delta;
    logic [fcfsa_pkg::DATA_W-1:0]         total_elapsed;
    logic [fcfsa_pkg::DATA_W-1:0]         frames_done;
    logic [fcfsa_pkg::DATA_W-1:0]         pending_steps;
    logic                                 is_running;
    logic                                 is_paused;
    logic [fcfsa_pkg::DATA_W-1:0]         change_count;

    modport source (
        output valid, output accepted, output consumed_steps, output last_tick,
        output frame_delta, output total_elapsed, output frames_done,
        output pending_steps, output is_running, output is_paused,
        output change_count, input ready
    );
    modport sink (
        input valid, input accepted, input consumed_steps, input last_tick,
        input frame_delta, input total_elapsed, input frames_done,
        input pending_steps, input is_running, input is_paused,
        input change_count, output ready
    );
endinterface

// ----- hdl/frame_clock_fixed_step_accumulator.sv -----
// top level of the frame clock with fixed-step accumulator
//
// Usage:
//   cmd carries one request (req_type, tick_value) per valid/ready handshake;
//   rsp returns one result per request with the clock state after it.
//   The APB port holds fixed_step_size at address 0x0 and lock_enable at
//   address 0x8; writes land on the access cycle, pready is always high.
// Sequencing:
//   after acceptance, start, stop, pause, resume, consume and rejected
//   requests pass EXEC and then RESP; paused updates and advances pass EXEC,
//   DELTA and RESP; unpaused ones pass EXEC, DELTA, ACCUM and RESP when the
//   step size is zero, and add DIVGO, DIVWAIT and FINISH before RESP when it
//   is nonzero, where the 64 iterations of the restoring divider reduce the
//   accumulator modulo the step. One request is in flight at a time; cmd
//   ready returns once the result is in the output register.
// Reset:
//   rst_n clears the clock state, both registers, and the output valid flag;
//   the change count restarts at one.
// Receiver stall:
//   the result waits in the output register; the next request may still be
//   taken, and its result holds in the sequencer until the register frees.
module frame_clock_fixed_step_accumulator (
    input  logic                              clk,
    input  logic                              rst_n,
    fcfsa_cmd_if.sink                         cmd,
    fcfsa_rsp_if.source                       rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fcfsa_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [fcfsa_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [fcfsa_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                              pready
);

    fcfsa_pkg::cfg_wr_t                 cfg_wr;
    fcfsa_pkg::cfg_rd_t                 cfg_rd;
    fcfsa_pkg::div_stat_t               div_stat;
    logic                               div_start;
    logic [fcfsa_pkg::DATA_W-1:0]       div_dividend;
    logic [fcfsa_pkg::DATA_W-1:0]       div_divisor;
    logic [fcfsa_pkg::DATA_W-1:0]       div_quo;
    logic [fcfsa_pkg::DATA_W-1:0]       div_rem;
    logic                               wr_fire;
    logic                               sel_lock;

    // apb write decode
    assign pready   = 1'b1;
    assign wr_fire  = psel && penable && pwrite && pready;
    assign sel_lock = paddr[fcfsa_pkg::CFG_SEL_BIT];

    always_comb
    begin
        cfg_wr.step_we = wr_fire && (sel_lock == fcfsa_pkg::CFG_IDX_STEP);
        cfg_wr.lock_we = wr_fire && (sel_lock == fcfsa_pkg::CFG_IDX_LOCK);
        cfg_wr.data    = pwdata;
    end

    // apb readback
    always_comb
    begin
        if (sel_lock == fcfsa_pkg::CFG_IDX_LOCK)
        begin
            prdata = {{(fcfsa_pkg::CFG_DATA_W-1){1'b0}}, cfg_rd.lock};
        end
        else
        begin
            prdata = cfg_rd.step_size;
        end
    end

    // sequencer and state
    fcfsa_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rsp          (rsp),
        .cfg_wr       (cfg_wr),
        .cfg_rd       (cfg_rd),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_stat     (div_stat),
        .div_quo      (div_quo),
        .div_rem      (div_rem)
    );

    // restoring divider
    fcfsa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

endmodule

// ----- hdl/fcfsa_div.sv -----
// restoring divider, one quotient bit per cycle
module fcfsa_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fcfsa_pkg::DATA_W-1:0]  dividend,
    input  logic [fcfsa_pkg::DATA_W-1:0]  divisor,
    output fcfsa_pkg::div_stat_t          stat,
    output logic [fcfsa_pkg::DATA_W-1:0]  quotient,
    output logic [fcfsa_pkg::DATA_W-1:0]  remainder
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [fcfsa_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [fcfsa_pkg::DATA_W-1:0]     quo_reg, quo_next;
    logic [fcfsa_pkg::DATA_W-1:0]     rem_reg, rem_next;
    logic [fcfsa_pkg::DATA_W-1:0]     divisor_reg, divisor_next;
    logic [fcfsa_pkg::DATA_W:0]       trial;
    logic [fcfsa_pkg::DATA_W:0]       diff;

    // one shift and trial subtract
    assign trial = {rem_reg, quo_reg[fcfsa_pkg::DATA_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};

    // iteration control
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = fcfsa_pkg::DIV_CNT_W'(fcfsa_pkg::DIV_STEPS);
            quo_next     = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            if (diff[fcfsa_pkg::DATA_W])
            begin
                rem_next = trial[fcfsa_pkg::DATA_W-1:0];
                quo_next = {quo_reg[fcfsa_pkg::DATA_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[fcfsa_pkg::DATA_W-1:0];
                quo_next = {quo_reg[fcfsa_pkg::DATA_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == fcfsa_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- hdl/fcfsa_core.sv -----
// command sequencer and clock state of the frame clock accumulator
module fcfsa_core (
    input  logic                          clk,
    input  logic                          rst_n,
    fcfsa_cmd_if.sink                     cmd,
    fcfsa_rsp_if.source                   rsp,
    input  fcfsa_pkg::cfg_wr_t            cfg_wr,
    output fcfsa_pkg::cfg_rd_t            cfg_rd,
    output logic                          div_start,
    output logic [fcfsa_pkg::DATA_W-1:0]  div_dividend,
    output logic [fcfsa_pkg::DATA_W-1:0]  div_divisor,
    input  fcfsa_pkg::div_stat_t          div_stat,
    input  logic [fcfsa_pkg::DATA_W-1:0]  div_quo,
    input  logic [fcfsa_pkg::DATA_W-1:0]  div_rem
);

    localparam int W = fcfsa_pkg::DATA_W;

    fcfsa_pkg::fsm_t                state_reg, state_next;

    // latched command
    logic [fcfsa_pkg::REQ_W-1:0]    req_reg, req_next;
    logic [W-1:0]                   tv_reg, tv_next;
    logic [W-1:0]                   target_reg, target_next;
    logic                           ok_reg, ok_next;
    logic [W-1:0]                   handed_reg, handed_next;

    // clock state
    logic [W-1:0]                   tick_now_reg, tick_now_next;
    logic [W-1:0]                   delta_reg, delta_next;
    logic [W-1:0]                   elapsed_reg, elapsed_next;
    logic [W-1:0]                   frames_reg, frames_next;
    logic [W-1:0]                   accum_reg, accum_next;
    logic [W-1:0]                   steps_reg, steps_next;
    logic                           run_reg, run_next;
    logic                           pause_reg, pause_next;
    logic [W-1:0]                   gen_reg, gen_next;

    // configuration
    logic [W-1:0]                   step_size_reg, step_size_next;
    logic                           lock_reg, lock_next;

    // response register
    fcfsa_pkg::rsp_t                rsp_reg, rsp_next;
    logic                           rsp_valid_reg, rsp_valid_next;

    logic                           cmd_fire;
    logic                           rsp_free;
    logic                           step_on;
    logic                           timed_req;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign step_on   = (step_size_reg != '0);
    assign timed_req = (req_reg == fcfsa_pkg::REQ_UPDATE) ||
                       (req_reg == fcfsa_pkg::REQ_ADVANCE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fcfsa_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = fcfsa_pkg::ST_EXEC;
                end
            end
            fcfsa_pkg::ST_EXEC:
            begin
                if ((req_reg <= fcfsa_pkg::REQ_LAST_CLK) && !lock_reg && run_reg && timed_req)
                begin
                    state_next = fcfsa_pkg::ST_DELTA;
                end
                else
                begin
                    state_next = fcfsa_pkg::ST_RESP;
                end
            end
            fcfsa_pkg::ST_DELTA:
            begin
                state_next = pause_reg ? fcfsa_pkg::ST_RESP : fcfsa_pkg::ST_ACCUM;
            end
            fcfsa_pkg::ST_ACCUM:
            begin
                state_next = step_on ? fcfsa_pkg::ST_DIVGO : fcfsa_pkg::ST_RESP;
            end
            fcfsa_pkg::ST_DIVGO:
            begin
                state_next = fcfsa_pkg::ST_DIVWAIT;
            end
            fcfsa_pkg::ST_DIVWAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = fcfsa_pkg::ST_FINISH;
                end
            end
            fcfsa_pkg::ST_FINISH:
            begin
                state_next = fcfsa_pkg::ST_RESP;
            end
            fcfsa_pkg::ST_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = fcfsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fcfsa_pkg::ST_IDLE;
            end
        endcase
    end

    // state updates per sequencer step
    always_comb
    begin
        req_next       = req_reg;
        tv_next        = tv_reg;
        target_next    = target_reg;
        ok_next        = ok_reg;
        handed_next    = handed_reg;
        tick_now_next  = tick_now_reg;
        delta_next     = delta_reg;
        elapsed_next   = elapsed_reg;
        frames_next    = frames_reg;
        accum_next     = accum_reg;
        steps_next     = steps_reg;
        run_next       = run_reg;
        pause_next     = pause_reg;
        gen_next       = gen_reg;
        step_size_next = step_size_reg;
        lock_next      = lock_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        // response taken downstream
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            fcfsa_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    req_next    = cmd.req_type;
                    tv_next     = cmd.tick_value & fcfsa_pkg::TICK_MAX;
                    ok_next     = 1'b0;
                    handed_next = '0;
                end
            end
            fcfsa_pkg::ST_EXEC:
            begin
                if (req_reg == fcfsa_pkg::REQ_CONSUME)
                begin
                    if (step_on)
                    begin
                        handed_next = steps_reg;
                        steps_next  = '0;
                        ok_next     = 1'b1;
                    end
                end
                else if ((req_reg <= fcfsa_pkg::REQ_LAST_CLK) && !lock_reg)
                begin
                    case (req_reg)
                        fcfsa_pkg::REQ_UPDATE:
                        begin
                            if (run_reg)
                            begin
                                target_next = tv_reg;
                                ok_next     = 1'b1;
                            end
                        end
                        fcfsa_pkg::REQ_ADVANCE:
                        begin
                            if (run_reg)
                            begin
                                target_next = fcfsa_pkg::sat_add(tick_now_reg, tv_reg,
                                                                 fcfsa_pkg::TICK_MAX);
                                ok_next     = 1'b1;
                            end
                        end
                        fcfsa_pkg::REQ_START:
                        begin
                            tick_now_next = tv_reg;
                            elapsed_next  = '0;
                            delta_next    = '0;
                            accum_next    = '0;
                            frames_next   = '0;
                            steps_next    = '0;
                            run_next      = 1'b1;
                            pause_next    = 1'b0;
                            gen_next      = gen_reg + 1'b1;
                            ok_next       = 1'b1;
                        end
                        fcfsa_pkg::REQ_STOP:
                        begin
                            run_next   = 1'b0;
                            pause_next = 1'b0;
                            gen_next   = gen_reg + 1'b1;
                            ok_next    = 1'b1;
                        end
                        fcfsa_pkg::REQ_PAUSE, fcfsa_pkg::REQ_RESUME:
                        begin
                            if (run_reg)
                            begin
                                pause_next = (req_reg == fcfsa_pkg::REQ_PAUSE);
                                gen_next   = gen_reg + 1'b1;
                                ok_next    = 1'b1;
                            end
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            fcfsa_pkg::ST_DELTA:
            begin
                // backward tick or a paused clock gives a zero delta
                tick_now_next = target_reg;
                if (pause_reg || (target_reg < tick_now_reg))
                begin
                    delta_next = '0;
                end
                else
                begin
                    delta_next = target_reg - tick_now_reg;
                end
            end
            fcfsa_pkg::ST_ACCUM:
            begin
                elapsed_next = fcfsa_pkg::sat_add(elapsed_reg, delta_reg, fcfsa_pkg::TICK_MAX);
                frames_next  = frames_reg + 1'b1;
                if (step_on)
                begin
                    accum_next = fcfsa_pkg::sat_add(accum_reg, delta_reg, fcfsa_pkg::TICK_MAX);
                end
                else
                begin
                    gen_next = gen_reg + 1'b1;
                end
            end
            fcfsa_pkg::ST_FINISH:
            begin
                accum_next = div_rem;
                steps_next = fcfsa_pkg::sat_add(steps_reg, div_quo, fcfsa_pkg::WORD_MAX);
                gen_next   = gen_reg + 1'b1;
            end
            fcfsa_pkg::ST_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_next.accepted       = ok_reg;
                    rsp_next.consumed_steps = handed_reg;
                    rsp_next.last_tick      = tick_now_reg;
                    rsp_next.frame_delta    = delta_reg;
                    rsp_next.total_elapsed  = elapsed_reg;
                    rsp_next.frames_done    = frames_reg;
                    rsp_next.pending_steps  = steps_reg;
                    rsp_next.is_running     = run_reg;
                    rsp_next.is_paused      = pause_reg;
                    rsp_next.change_count   = gen_reg;
                    rsp_valid_next          = 1'b1;
                end
            end
            default:
            begin
                ok_next = ok_reg;
            end
        endcase

        // register writes must arrive only while the sequencer is idle; the block itself does not enforce this
        if (cfg_wr.step_we && !lock_reg)
        begin
            step_size_next = cfg_wr.data;
            accum_next     = '0;
            gen_next       = gen_reg + 1'b1;
        end
        if (cfg_wr.lock_we)
        begin
            lock_next = cfg_wr.data[0];
        end
    end

    // control and clock state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcfsa_pkg::ST_IDLE;
            tick_now_reg  <= '0;
            delta_reg     <= '0;
            elapsed_reg   <= '0;
            frames_reg    <= '0;
            accum_reg     <= '0;
            steps_reg     <= '0;
            run_reg       <= 1'b0;
            pause_reg     <= 1'b0;
            gen_reg       <= W'(1);
            step_size_reg <= '0;
            lock_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_now_reg  <= tick_now_next;
            delta_reg     <= delta_next;
            elapsed_reg   <= elapsed_next;
            frames_reg    <= frames_next;
            accum_reg     <= accum_next;
            steps_reg     <= steps_next;
            run_reg       <= run_next;
            pause_reg     <= pause_next;
            gen_reg       <= gen_next;
            step_size_reg <= step_size_next;
            lock_reg      <= lock_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // command and response payload
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        tv_reg     <= tv_next;
        target_reg <= target_next;
        ok_reg     <= ok_next;
        handed_reg <= handed_next;
        rsp_reg    <= rsp_next;
    end

    // outputs
    always_comb
    begin
        cmd.ready          = (state_reg == fcfsa_pkg::ST_IDLE);
        div_start          = (state_reg == fcfsa_pkg::ST_DIVGO);
        div_dividend       = accum_reg;
        div_divisor        = step_size_reg;
        cfg_rd.step_size   = step_size_reg;
        cfg_rd.lock        = lock_reg;
        rsp.valid          = rsp_valid_reg;
        rsp.accepted       = rsp_reg.accepted;
        rsp.consumed_steps = rsp_reg.consumed_steps;
        rsp.last_tick      = rsp_reg.last_tick;
        rsp.frame_delta    = rsp_reg.frame_delta;
        rsp.total_elapsed  = rsp_reg.total_elapsed;
        rsp.frames_done    = rsp_reg.frames_done;
        rsp.pending_steps  = rsp_reg.pending_steps;
        rsp.is_running     = rsp_reg.is_running;
        rsp.is_paused      = rsp_reg.is_paused;
        rsp.change_count   = rsp_reg.change_count;
    end

endmodule

// ----- hdl/fcfsa_checker.sv -----
// port-level assertions for the frame clock accumulator, bound to the top level
module fcfsa_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic                          cmd_ready,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic                          rsp_accepted,
    input  logic [fcfsa_pkg::DATA_W-1:0]  rsp_consumed_steps,
    input  logic                          rsp_is_running,
    input  logic                          rsp_is_paused
);

    // one request at a time in the sequencer
    a_busy_after_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready
    ) else $error("command ready while a request is in progress");

    // a stalled result stays offered
    a_rsp_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid
    ) else $error("result dropped while stalled");

    // steps are only handed out by an accepted consume
    a_rejected_no_steps: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_accepted) |-> (rsp_consumed_steps == '0)
    ) else $error("rejected request handed out steps");

    // pause only exists on a running clock
    a_pause_needs_run: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_is_paused) |-> rsp_is_running
    ) else $error("paused flag set on a stopped clock");

endmodule

bind frame_clock_fixed_step_accumulator fcfsa_checker u_fcfsa_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd.valid),
    .cmd_ready          (cmd.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_accepted       (rsp.accepted),
    .rsp_consumed_steps (rsp.consumed_steps),
    .rsp_is_running     (rsp.is_running),
    .rsp_is_paused      (rsp.is_paused)
);
